[sv/error_diffusion_dither_unit_macros.svh]
// Assertion macros for the error diffusion dither unit.
// Included by sv/error_diffusion_dither_unit.sv; no other dependencies.
`ifndef ERROR_DIFFUSION_DITHER_UNIT_MACROS_SVH
`define ERROR_DIFFUSION_DITHER_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define EDD_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked out of reset
`define EDD_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/edd_pkg.sv]
// Types and constants of the error diffusion dither unit.
// No dependencies; imported by sv/error_diffusion_dither_unit.sv.
package edd_pkg;

  localparam int PIX_W   = 8;
  localparam int LVL_W   = 3;
  localparam int LW_W    = 13;
  localparam int ERR_W   = 7;
  localparam int STORE_W = 6;
  localparam int CARRY_W = 5;
  localparam int SUM_W   = 10;
  localparam int NUM_LEVELS = 5;

  localparam logic [LW_W-1:0] LINE_WIDTH_RESET = 13'd640;

  typedef logic [PIX_W-1:0]          pix_t;
  typedef logic [LVL_W-1:0]          lvl_t;
  typedef logic signed [ERR_W-1:0]   err_t;
  typedef logic signed [STORE_W-1:0] store_err_t;
  typedef logic signed [CARRY_W-1:0] carry_t;
  typedef logic signed [SUM_W-1:0]   sum_t;

  // output levels and the lowest clamped input that selects each
  localparam pix_t LEVEL_VALUE [NUM_LEVELS] = '{8'd0, 8'd63, 8'd127, 8'd191, 8'd255};
  localparam pix_t LEVEL_LOW   [NUM_LEVELS] = '{8'd0, 8'd32, 8'd96, 8'd160, 8'd224};

  // Floyd-Steinberg weights in sixteenths
  localparam logic [2:0] WEIGHT_RIGHT      = 3'd7;
  localparam logic [2:0] WEIGHT_BELOW_LEFT = 3'd3;
  localparam logic [2:0] WEIGHT_BELOW      = 3'd5;
  localparam logic [2:0] WEIGHT_BELOW_RIGHT = 3'd1;

endpackage

[sv/error_diffusion_dither_unit.sv]
// Five-level Floyd-Steinberg error diffusion on a raster grayscale pixel stream.
// Depends on edd_pkg and error_diffusion_dither_unit_macros.svh.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-----------------------------
//  pixel   | in        | pixel_valid/stall     | pixel_value, frame_start
//  result  | out       | result_valid/stall    | dithered_value, level_index
//  cfg     | in        | cfg_valid/cfg_ready   | cfg_data (line_width)
//
// One pixel per clock sustained while results are not stalled; a pixel passes the input stage register
// (row store read as the pixel is taken), then the diffusion logic into the output register.
// Synchronous reset clears control state; the row error store is not cleared and
// holds undefined data until a row has written it.
// A stalled result holds the output register; the input stage still takes a pixel
// while it is empty or moving on in the same cycle.
`include "error_diffusion_dither_unit_macros.svh"

module error_diffusion_dither_unit
  import edd_pkg::*;
#(
  parameter int MAX_WIDTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              pixel_valid,
  output logic              pixel_stall,
  input  pix_t              pixel_value,
  input  logic              frame_start,
  output logic              result_valid,
  input  logic              result_stall,
  output pix_t              dithered_value,
  output lvl_t              level_index,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [LW_W-1:0]   cfg_data
);

  localparam int AW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  typedef logic [AW-1:0] col_t;

  typedef struct packed {
    pix_t pix;
    logic fs;
    logic first;
    logic eor;
    col_t col;
  } s1_t;

  function automatic store_err_t share(input err_t e, input logic [2:0] w);
    logic [ERR_W-1:0]   mag;
    logic [ERR_W+2:0]   prod;
    logic [STORE_W-1:0] q;
    mag  = e[ERR_W-1] ? ERR_W'(-e) : ERR_W'(e);
    prod = (ERR_W+3)'(mag) * (ERR_W+3)'(w);
    q    = STORE_W'(prod >> 4);
    return e[ERR_W-1] ? store_err_t'(-q) : store_err_t'(q);
  endfunction

  logic [LW_W-1:0] line_width;
  col_t            column_counter;
  logic            first_row;
  carry_t          rce;
  store_err_t      dps0;
  store_err_t      dps1;

  logic            s1_valid;
  s1_t             s1;
  store_err_t      s1_rd;

  store_err_t      row_mem [MAX_WIDTH];

  // end-of-row share waiting for a free write cycle
  logic            pend_valid;
  logic            pend_live;
  col_t            pend_addr;
  store_err_t      pend_data;

  // last regular store write, for reads issued in the same cycle
  logic            fw_valid;
  col_t            fw_addr;
  store_err_t      fw_data;

  col_t            last_col;
  col_t            in_col;
  logic            in_eor;
  logic            in_first;
  logic            pixel_accept;
  logic            s1_adv;

  carry_t          rce_in;
  store_err_t      dps0_in;
  store_err_t      dps1_in;
  store_err_t      store_term;
  sum_t            sum;
  pix_t            clamped;
  lvl_t            lvl;
  pix_t            lvl_value;
  sum_t            diff;
  err_t            e;
  store_err_t      s7;
  store_err_t      s3;
  store_err_t      s5;
  store_err_t      s1w;
  store_err_t      dps0_new;

  logic            normal_we;
  col_t            normal_addr;
  store_err_t      normal_data;
  logic            mem_we;
  col_t            mem_waddr;
  store_err_t      mem_wdata;

  logic            pend_valid_next;
  logic            pend_live_next;
  carry_t          rce_next;
  store_err_t      dps0_next;
  store_err_t      dps1_next;

  assign cfg_ready = 1'b1;

  // input stage: column tracking and row store read
  always_comb begin
    if (32'(line_width) > 32'(MAX_WIDTH)) begin
      last_col = col_t'(MAX_WIDTH - 1);
    end else if (line_width == '0) begin
      last_col = '0;
    end else begin
      last_col = col_t'(line_width - LW_W'(1));
    end
    in_col   = frame_start ? '0 : column_counter;
    in_eor   = (in_col >= last_col);
    in_first = frame_start ? 1'b1 : first_row;
  end

  assign s1_adv       = s1_valid && (!result_valid || !result_stall);
  assign pixel_stall  = s1_valid && !s1_adv;
  assign pixel_accept = pixel_valid && !pixel_stall;

  // diffusion stage
  always_comb begin
    rce_in  = s1.fs ? '0 : rce;
    dps0_in = s1.fs ? '0 : dps0;
    dps1_in = s1.fs ? '0 : dps1;

    if (pend_live && (pend_addr == s1.col)) begin
      store_term = pend_data;
    end else if (fw_valid && (fw_addr == s1.col)) begin
      store_term = fw_data;
    end else begin
      store_term = s1_rd;
    end

    sum = sum_t'({2'b00, s1.pix}) + SUM_W'(rce_in);
    if (!s1.first) begin
      sum = sum + SUM_W'(store_term);
    end

    if (sum < 0) begin
      clamped = '0;
    end else if (sum > sum_t'(255)) begin
      clamped = 8'd255;
    end else begin
      clamped = sum[PIX_W-1:0];
    end

    priority if (clamped >= LEVEL_LOW[4]) begin
      lvl = 3'd4;
    end else if (clamped >= LEVEL_LOW[3]) begin
      lvl = 3'd3;
    end else if (clamped >= LEVEL_LOW[2]) begin
      lvl = 3'd2;
    end else if (clamped >= LEVEL_LOW[1]) begin
      lvl = 3'd1;
    end else begin
      lvl = 3'd0;
    end
    lvl_value = LEVEL_VALUE[lvl];

    diff = sum_t'({2'b00, clamped}) - sum_t'({2'b00, lvl_value});
    e    = ERR_W'(diff);

    s7  = share(e, WEIGHT_RIGHT);
    s3  = share(e, WEIGHT_BELOW_LEFT);
    s5  = share(e, WEIGHT_BELOW);
    s1w = share(e, WEIGHT_BELOW_RIGHT);

    dps0_new    = dps1_in + s5;
    normal_we   = s1_adv && (s1.col != '0);
    normal_addr = col_t'(s1.col - col_t'(1));
    normal_data = dps0_in + s3;

    mem_we    = normal_we || pend_valid;
    mem_waddr = normal_we ? normal_addr : pend_addr;
    mem_wdata = normal_we ? normal_data : pend_data;

    if (s1_adv && s1.eor) begin
      pend_valid_next = 1'b1;
      pend_live_next  = 1'b1;
    end else begin
      pend_valid_next = normal_we ? pend_valid : 1'b0;
      pend_live_next  = (normal_we && (normal_addr == pend_addr)) ? 1'b0 : pend_live;
    end

    rce_next  = rce;
    dps0_next = dps0;
    dps1_next = dps1;
    if (s1_adv) begin
      if (s1.eor) begin
        rce_next  = '0;
        dps0_next = '0;
        dps1_next = '0;
      end else begin
        rce_next  = CARRY_W'(s7);
        dps0_next = dps0_new;
        dps1_next = s1w;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      row_mem[mem_waddr] <= mem_wdata;
    end
    if (pixel_accept) begin
      s1_rd <= row_mem[in_col];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width     <= LINE_WIDTH_RESET;
      column_counter <= '0;
      first_row      <= 1'b1;
      rce            <= '0;
      dps0           <= '0;
      dps1           <= '0;
      s1_valid       <= 1'b0;
      result_valid   <= 1'b0;
      pend_valid     <= 1'b0;
      pend_live      <= 1'b0;
      fw_valid       <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        line_width <= cfg_data;
      end
      if (pixel_accept) begin
        column_counter <= in_eor ? '0 : col_t'(in_col + col_t'(1));
        first_row      <= in_eor ? 1'b0 : in_first;
        s1_valid       <= 1'b1;
      end else if (s1_adv) begin
        s1_valid <= 1'b0;
      end
      if (s1_adv) begin
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
      rce        <= rce_next;
      dps0       <= dps0_next;
      dps1       <= dps1_next;
      pend_valid <= pend_valid_next;
      pend_live  <= pend_live_next;
      if (normal_we) begin
        fw_valid <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pixel_accept) begin
      s1.pix   <= pixel_value;
      s1.fs    <= frame_start;
      s1.first <= in_first;
      s1.eor   <= in_eor;
      s1.col   <= in_col;
    end
    if (s1_adv) begin
      dithered_value <= lvl_value;
      level_index    <= lvl;
    end
    if (s1_adv && s1.eor) begin
      pend_addr <= s1.col;
      pend_data <= dps0_new;
    end
    if (normal_we) begin
      fw_addr <= normal_addr;
      fw_data <= normal_data;
    end
  end

  `EDD_ASSERT_NOW(a_pend_live, clk, rst, pend_valid, pend_live, "uncommitted row-end share is stale")
  `EDD_ASSERT_NOW(a_write_port, clk, rst, normal_we, !pend_valid, "row store write port conflict")
  `EDD_ASSERT_NEXT(a_row_wrap, clk, rst, pixel_accept && in_eor, (column_counter == '0) && !first_row, "row end did not wrap column")
  `EDD_ASSERT_NEXT(a_carry_clear, clk, rst, s1_adv && s1.eor, (rce == '0) && (dps0 == '0) && (dps1 == '0), "carries not cleared at row end")

endmodule

[sim/error_diffusion_dither_unit_tb.sv]
// Self-checking testbench for error_diffusion_dither_unit: random and directed pixel streams
// against an in-bench five-level error diffusion predictor, with line width sweeps.
// Depends on edd_pkg and the error_diffusion_dither_unit RTL.
module error_diffusion_dither_unit_tb
  import edd_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MAX_W = 4096;
  localparam int DEFAULT_LINE_WIDTH = 640;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int NUM_PHASES = 9;
  localparam int PHASE_WIDTH [NUM_PHASES] = '{0, 1, 2, 5, 8, 13, 33, 8191, 4096};
  localparam int PHASE_COUNT [NUM_PHASES] = '{30, 20, 30, 100, 20, 30, 40, 30, 20};
  localparam pix_t LEVELS [5] = '{8'd0, 8'd63, 8'd127, 8'd191, 8'd255};
  localparam pix_t EDGE_PIXELS [8] = '{8'd0, 8'd255, 8'd31, 8'd32, 8'd223, 8'd224, 8'd95, 8'd96};
  localparam pix_t CLAMP_PIXELS [12] = '{8'd223, 8'd255, 8'd224, 8'd0, 8'd32, 8'd31,
                                         8'd96, 8'd95, 8'd0, 8'd255, 8'd159, 8'd160};

  typedef struct packed {
    pix_t value;
    logic first;
  } pixel_txn_t;

  typedef struct packed {
    pix_t value;
    lvl_t index;
  } level_txn_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic pixel_valid = 1'b0;
  logic pixel_stall;
  pix_t pixel_value = '0;
  logic frame_start = 1'b0;
  logic result_valid;
  logic result_stall = 1'b0;
  pix_t dithered_value;
  lvl_t level_index;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [LW_W-1:0] cfg_data = '0;

  pixel_txn_t pixel_backlog [$];
  level_txn_t predicted_levels [$];
  int pixels_pending = 0;
  int mismatches = 0;
  int results_seen = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;
  logic pixel_accepted = 1'b0;
  logic cfg_taken = 1'b0;

  // predictor state
  int line_width_setting;
  store_err_t row_err [MAX_W];
  logic [11:0] column;
  bit first_row;
  carry_t right_err;
  store_err_t diag_err [2];

  error_diffusion_dither_unit #(.MAX_WIDTH(MAX_W)) dut (
    .clk(clk),
    .rst(rst),
    .pixel_valid(pixel_valid),
    .pixel_stall(pixel_stall),
    .pixel_value(pixel_value),
    .frame_start(frame_start),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .dithered_value(dithered_value),
    .level_index(level_index),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  function automatic bit want_gap();
    return !no_gaps && ($urandom_range(99) < 21);
  endfunction

  // weight/16 share, truncated toward zero
  function automatic int fs_share(input int err, input int weight);
    int mag;
    mag = (err < 0) ? -err : err;
    mag = (mag * weight) >>> 4;
    return (err < 0) ? -mag : mag;
  endfunction

  task automatic report_mismatch(input string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  task automatic dither_pixel(input pix_t pix, input logic first, output level_txn_t res);
    int w;
    int x;
    int sum;
    int idx;
    int err;
    bit row_end;
    w = line_width_setting;
    if (w == 0) w = 1;
    if (w > MAX_W) w = MAX_W;
    if (first) begin
      column = '0;
      first_row = 1'b1;
      right_err = '0;
      diag_err[0] = '0;
      diag_err[1] = '0;
    end
    x = int'(column);
    row_end = (x >= w - 1);
    sum = int'(pix) + int'(right_err);
    if (!first_row) sum += int'(row_err[x]);
    if (sum < 0) sum = 0;
    if (sum > 255) sum = 255;
    idx = (sum * 8 + 255) / 510;
    if (idx > 4) idx = 4;
    err = sum - int'(LEVELS[idx]);
    if (x > 0) row_err[x-1] = store_err_t'(int'(diag_err[0]) + fs_share(err, 3));
    diag_err[0] = store_err_t'(int'(diag_err[1]) + fs_share(err, 5));
    diag_err[1] = store_err_t'(fs_share(err, 1));
    if (row_end) begin
      row_err[x] = diag_err[0];
      diag_err[0] = '0;
      diag_err[1] = '0;
      right_err = '0;
      column = '0;
      first_row = 1'b0;
    end else begin
      right_err = carry_t'(fs_share(err, 7));
      column = 12'(x + 1);
    end
    res.value = LEVELS[idx];
    res.index = lvl_t'(idx);
  endtask

  // pixel driver
  always @(negedge clk) begin
    pixel_txn_t nxt;
    if (rst) begin
      pixel_valid <= 1'b0;
    end else if (!pixel_valid || pixel_accepted) begin
      if (pixel_backlog.size() != 0 && !want_gap()) begin
        nxt = pixel_backlog.pop_front();
        pixel_valid <= 1'b1;
        pixel_value <= nxt.value;
        frame_start <= nxt.first;
      end else begin
        pixel_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    result_stall <= rst ? 1'b0 : want_gap();
  end

  // monitor: checks results, tracks config and pixel transactions, watchdog
  always @(posedge clk) begin
    level_txn_t want;
    bit progress;
    pixel_accepted <= !rst && pixel_valid && !pixel_stall;
    cfg_taken <= !rst && cfg_valid && cfg_ready;
    if (rst) begin
      line_width_setting = DEFAULT_LINE_WIDTH;
      foreach (row_err[i]) row_err[i] = '0;
      column = '0;
      first_row = 1'b1;
      right_err = '0;
      diag_err[0] = '0;
      diag_err[1] = '0;
      idle_cycles = 0;
    end else begin
      progress = 1'b0;
      if (result_valid && !result_stall) begin
        progress = 1'b1;
        if (predicted_levels.size() == 0) begin
          report_mismatch($sformatf("unexpected result %0d/%0d", dithered_value, level_index));
        end else begin
          want = predicted_levels.pop_front();
          if (dithered_value !== want.value)
            report_mismatch($sformatf("dithered_value %0d, want %0d", dithered_value, want.value));
          if (level_index !== want.index)
            report_mismatch($sformatf("level_index %0d, want %0d", level_index, want.index));
        end
        results_seen++;
      end
      if (cfg_valid && cfg_ready) begin
        progress = 1'b1;
        line_width_setting = int'(cfg_data);
      end
      if (pixel_valid && !pixel_stall) begin
        progress = 1'b1;
        dither_pixel(pixel_value, frame_start, want);
        predicted_levels.push_back(want);
        pixels_pending--;
      end
      idle_cycles = progress ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  task automatic push_pixel(input pix_t value, input logic first);
    pixel_backlog.push_back('{value: value, first: first});
    pixels_pending++;
  endtask

  task automatic wait_drained();
    do @(negedge clk); while (pixels_pending != 0 || predicted_levels.size() != 0);
  endtask

  task automatic write_line_width(input int value);
    wait_drained();
    cfg_data <= value[LW_W-1:0];
    cfg_valid <= 1'b1;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid <= 1'b0;
  endtask

  // mostly whole rows and frames, with occasional frame restarts mid-row
  task automatic queue_pixels(input int count, input bit start_frame);
    int weff;
    int col;
    pix_t v;
    logic first;
    weff = line_width_setting;
    if (weff == 0) weff = 1;
    if (weff > MAX_W) weff = MAX_W;
    col = 0;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(7))
        0: v = 8'd0;
        1: v = 8'd255;
        default: v = pix_t'($urandom_range(255));
      endcase
      if (i == 0) first = start_frame;
      else if (col == 0) first = ($urandom_range(99) < 15);
      else first = (weff < 64) && ($urandom_range(99) < 2);
      if (first) col = 0;
      push_pixel(v, first);
      col = (col + 1) % weff;
    end
  endtask

  initial begin
    repeat (4) @(negedge clk);
    rst <= 1'b0;

    // reset line width, no frame start after reset
    for (int i = 0; i < 8; i++) push_pixel(EDGE_PIXELS[i], 1'b0);

    // clamping at both ends, frame restart mid-row
    write_line_width(3);
    for (int i = 0; i < 12; i++) push_pixel(CLAMP_PIXELS[i], (i == 0) || (i == 7));

    for (int i = 0; i < NUM_PHASES; i++) begin
      write_line_width(PHASE_WIDTH[i]);
      no_gaps = (PHASE_WIDTH[i] == 5);
      queue_pixels(PHASE_COUNT[i], 1'b1);
      if (PHASE_WIDTH[i] == 8) begin
        wait_drained();
        queue_pixels(30, 1'b0);
      end
    end
    no_gaps = 1'b0;

    // shrink mid-row: current column is past the new end
    write_line_width(7);
    queue_pixels(40, 1'b0);

    wait_drained();
    repeat (4) @(negedge clk);
    if (predicted_levels.size() != 0) report_mismatch("results missing at end");
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
